FILE: src/rcap_pkg.sv
// Shared types and constants for the RESP command array parser.
// Used by rcap_front, rcap_fifo, rcap_back and the top level; no dependencies.
package rcap_pkg;

  // Stream characters
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] Char0      = 8'h30;
  localparam logic [7:0] Char9      = 8'h39;

  // Number accumulator saturates here
  localparam logic [30:0] AccMax = 31'h7FFF_FFFF;

  // Hard ceiling on the argument count, combined with the max_args register
  localparam logic [10:0] MaxArgs = 11'd1024;

  // Configuration register indexes and reset values
  localparam logic [0:0]  CfgMaxArgs    = 1'b0;
  localparam logic [0:0]  CfgMaxBulkLen = 1'b1;
  localparam logic [10:0] MaxArgsRst    = 11'd1024;
  localparam logic [29:0] MaxBulkLenRst = 30'd536870912;

  // Error codes
  localparam logic [2:0] ErrArrayMark = 3'd0;
  localparam logic [2:0] ErrCount     = 3'd1;
  localparam logic [2:0] ErrBulkMark  = 3'd2;
  localparam logic [2:0] ErrLength    = 3'd3;
  localparam logic [2:0] ErrDataCrlf  = 3'd4;
  localparam logic [2:0] ErrBareCr    = 3'd5;

  // Event queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SKIP,
    PH_CNT,
    PH_CNT_LF,
    PH_MARK,
    PH_LEN,
    PH_LEN_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF
  } phase_e;

  // What the front hands to the back for one byte
  typedef enum logic [2:0] {
    OP_DATA,
    OP_ARG,
    OP_ARG_CMD,
    OP_CMD,
    OP_ERR
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_ARG_END,
    KIND_CMD_END,
    KIND_ERROR
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [9:0] arg;
    logic [2:0] err;
  } event_t;

  typedef struct packed {
    logic [10:0] max_args;
    logic [29:0] max_bulk_len;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

FILE: src/rcap_front.sv
// Front end: byte-at-a-time RESP parser state machine.
// Classifies each accepted byte and pushes at most one event into the queue.
// Depends on rcap_pkg.
module rcap_front import rcap_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output logic       push_o,
  output event_t     event_o
);

  phase_e      phase_q, phase_d;
  logic [30:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic        digit_q, digit_d;
  logic        started_q, started_d;
  logic        done_q, done_d;
  logic [10:0] args_left_q, args_left_d;
  logic [9:0]  arg_cnt_q, arg_cnt_d;
  logic [29:0] bytes_left_q, bytes_left_d;

  // Number-line helpers
  logic        is_digit, is_space;
  logic [34:0] acc_mul;
  logic [10:0] count_limit;
  logic [10:0] args_dec;
  logic [29:0] bytes_dec;

  logic        fail_en, finish_en;
  logic [2:0]  fail_code;

  assign is_digit    = (byte_i >= Char0) && (byte_i <= Char9);
  assign is_space    = (byte_i == CharSpace) || ((byte_i >= CharTab) && (byte_i <= CharCr));
  assign acc_mul     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                     + {27'd0, byte_i - Char0};
  assign count_limit = (cfg_i.max_args < MaxArgs) ? cfg_i.max_args : MaxArgs;
  assign args_dec    = args_left_q - 11'd1;
  assign bytes_dec   = bytes_left_q - 30'd1;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      acc_q        <= '0;
      neg_q        <= 1'b0;
      digit_q      <= 1'b0;
      started_q    <= 1'b0;
      done_q       <= 1'b0;
      args_left_q  <= '0;
      arg_cnt_q    <= '0;
      bytes_left_q <= '0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      acc_q        <= acc_d;
      neg_q        <= neg_d;
      digit_q      <= digit_d;
      started_q    <= started_d;
      done_q       <= done_d;
      args_left_q  <= args_left_d;
      arg_cnt_q    <= arg_cnt_d;
      bytes_left_q <= bytes_left_d;
    end
  end

  // Next state and event
  always_comb begin
    phase_d      = phase_q;
    acc_d        = acc_q;
    neg_d        = neg_q;
    digit_d      = digit_q;
    started_d    = started_q;
    done_d       = done_q;
    args_left_d  = args_left_q;
    arg_cnt_d    = arg_cnt_q;
    bytes_left_d = bytes_left_q;
    fail_en      = 1'b0;
    fail_code    = ErrArrayMark;
    finish_en    = 1'b0;
    push_o       = 1'b0;
    event_o      = '{op: OP_DATA, data: 8'd0, arg: arg_cnt_q, err: 3'd0};

    unique case (phase_q)
      PH_IDLE: begin
        if (byte_i == CharStar) begin
          phase_d = PH_CNT;
        end else begin
          fail_en   = 1'b1;
          fail_code = ErrArrayMark;
        end
      end
      PH_CNT, PH_LEN: begin
        if (byte_i == CharCr) begin
          phase_d = (phase_q == PH_CNT) ? PH_CNT_LF : PH_LEN_LF;
        end else if (!done_q) begin
          // stoi-like scan: whitespace, sign, digits, then anything ends it
          if (is_digit) begin
            acc_d     = (acc_mul > {4'd0, AccMax}) ? AccMax : acc_mul[30:0];
            digit_d   = 1'b1;
            started_d = 1'b1;
          end else if (!started_q && is_space) begin
            started_d = 1'b0;
          end else if (!started_q && (byte_i == CharPlus || byte_i == CharMinus)) begin
            started_d = 1'b1;
            neg_d     = (byte_i == CharMinus);
          end else begin
            done_d = 1'b1;
          end
        end
      end
      PH_CNT_LF: begin
        if (byte_i != CharLf) begin
          fail_en   = 1'b1;
          fail_code = ErrBareCr;
        end else if (!digit_q || (neg_q && acc_q != '0)
                     || (acc_q > {20'd0, count_limit})) begin
          fail_en   = 1'b1;
          fail_code = ErrCount;
        end else begin
          args_left_d = acc_q[10:0];
          arg_cnt_d   = '0;
          if (acc_q == '0) begin
            push_o     = 1'b1;
            event_o.op = OP_CMD;
            phase_d    = PH_IDLE;
          end else begin
            phase_d = PH_MARK;
          end
        end
      end
      PH_LEN_LF: begin
        if (byte_i != CharLf) begin
          fail_en   = 1'b1;
          fail_code = ErrBareCr;
        end else if (!digit_q) begin
          fail_en   = 1'b1;
          fail_code = ErrLength;
        end else if (neg_q && acc_q == 31'd1) begin
          // null bulk string: empty argument
          finish_en = 1'b1;
        end else if ((neg_q && acc_q != '0)
                     || (!neg_q && acc_q > {1'b0, cfg_i.max_bulk_len})) begin
          fail_en   = 1'b1;
          fail_code = ErrLength;
        end else begin
          bytes_left_d = acc_q[29:0];
          phase_d      = (acc_q[29:0] != '0) ? PH_DATA : PH_DATA_CR;
        end
      end
      PH_MARK: begin
        if (byte_i != CharDollar) begin
          fail_en   = 1'b1;
          fail_code = ErrBulkMark;
        end else begin
          acc_d     = '0;
          neg_d     = 1'b0;
          digit_d   = 1'b0;
          started_d = 1'b0;
          done_d    = 1'b0;
          phase_d   = PH_LEN;
        end
      end
      PH_DATA: begin
        push_o       = 1'b1;
        event_o.op   = OP_DATA;
        event_o.data = byte_i;
        bytes_left_d = bytes_dec;
        if (bytes_dec == '0) begin
          phase_d = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (byte_i != CharCr) begin
          fail_en   = 1'b1;
          fail_code = ErrDataCrlf;
        end else begin
          phase_d = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (byte_i != CharLf) begin
          fail_en   = 1'b1;
          fail_code = ErrDataCrlf;
        end else begin
          finish_en = 1'b1;
        end
      end
      default: begin
        // resync: drop bytes until the next array marker
        phase_d = (byte_i == CharStar) ? PH_CNT : PH_SKIP;
      end
    endcase

    // New command: clear counters and number scan
    if (phase_d == PH_CNT && (phase_q == PH_IDLE || phase_q == PH_SKIP
                              || !(phase_q == PH_CNT))) begin
      args_left_d  = '0;
      arg_cnt_d    = '0;
      bytes_left_d = '0;
      acc_d        = '0;
      neg_d        = 1'b0;
      digit_d      = 1'b0;
      started_d    = 1'b0;
      done_d       = 1'b0;
    end

    // Close an argument, and the command with it when none remain
    if (finish_en) begin
      push_o      = 1'b1;
      arg_cnt_d   = arg_cnt_q + 10'd1;
      args_left_d = args_dec;
      if (args_dec == '0) begin
        event_o.op = OP_ARG_CMD;
        phase_d    = PH_IDLE;
      end else begin
        event_o.op = OP_ARG;
        phase_d    = PH_MARK;
      end
    end

    if (fail_en) begin
      push_o      = 1'b1;
      event_o.op  = OP_ERR;
      event_o.err = fail_code;
      phase_d     = PH_SKIP;
    end
  end

  // A command-closing event always leaves the parser idle
  a_cmd_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && push_o && (event_o.op == OP_ARG_CMD || event_o.op == OP_CMD)
      |=> phase_q == PH_IDLE)
    else $error("command end without return to idle");

endmodule

FILE: src/rcap_fifo.sv
// Small event queue between the parser front end and the result back end.
// Registers only; depth from rcap_pkg::FifoDepth. Depends on rcap_pkg.
module rcap_fifo import rcap_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  event_t       event_i,
  input  logic         pop_i,
  output event_t       head_o,
  output fifo_status_t status_o
);

  event_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_q, rd_q;
  logic [FifoCntW-1:0]   cnt_q;

  assign status_o.full  = (cnt_q == FifoCntW'(FifoDepth));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= event_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full || pop_i)
    else $error("push into full event queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty event queue");

endmodule

FILE: src/rcap_back.sv
// Back end: expands queued events into result transfers, one per cycle while the output is not stalled.
// Holds the output register; depends on rcap_pkg.
module rcap_back import rcap_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  event_t       head_i,
  input  fifo_status_t status_i,
  output logic         pop_o,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output logic [1:0]   kind_o,
  output logic [7:0]   data_byte_o,
  output logic [9:0]   arg_index_o,
  output logic [2:0]   err_code_o,
  output logic         last_o
);

  logic       valid_q, valid_d;
  logic       half_q, half_d;
  logic       load;
  kind_e      kind_q, kind_d;
  logic [7:0] data_q, data_d;
  logic [9:0] arg_q, arg_d;
  logic [2:0] err_q, err_d;
  logic       last_q, last_d;

  assign load = !valid_q || !out_stall_i;

  // Map the head event to the next result
  always_comb begin
    valid_d = valid_q;
    half_d  = half_q;
    pop_o   = 1'b0;
    kind_d  = kind_q;
    data_d  = data_q;
    arg_d   = arg_q;
    err_d   = err_q;
    last_d  = last_q;
    if (load) begin
      valid_d = !status_i.empty;
      if (!status_i.empty) begin
        data_d = 8'd0;
        arg_d  = head_i.arg;
        err_d  = 3'd0;
        last_d = 1'b1;
        pop_o  = 1'b1;
        unique case (head_i.op)
          OP_DATA: begin
            kind_d = KIND_DATA;
            data_d = head_i.data;
          end
          OP_ARG: kind_d = KIND_ARG_END;
          OP_ARG_CMD: begin
            // two results: argument end, then command end
            if (!half_q) begin
              kind_d = KIND_ARG_END;
              last_d = 1'b0;
              pop_o  = 1'b0;
              half_d = 1'b1;
            end else begin
              kind_d = KIND_CMD_END;
              arg_d  = 10'd0;
              half_d = 1'b0;
            end
          end
          OP_CMD: begin
            kind_d = KIND_CMD_END;
            arg_d  = 10'd0;
          end
          OP_ERR: begin
            kind_d = KIND_ERROR;
            err_d  = head_i.err;
          end
          default: begin
            kind_d = KIND_ERROR;
            err_d  = head_i.err;
          end
        endcase
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
    arg_q  <= arg_d;
    err_q  <= err_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign data_byte_o = data_q;
  assign arg_index_o = arg_q;
  assign err_code_o  = err_q;
  assign last_o      = last_q;

  a_half_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> !status_i.empty)
    else $error("split event lost from queue");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !last_q && !out_stall_i |=> valid_q && kind_q == KIND_CMD_END)
    else $error("argument end not followed by command end");

endmodule

FILE: src/resp_command_array_parser_unit.sv
// RESP command array parser: takes one request byte per cycle and returns data bytes,
// argument and command end marks and error codes. Top level; depends on rcap_pkg,
// rcap_front, rcap_fifo and rcap_back.
//
// The block accepts one byte every cycle while its four-entry event queue has room.
// A byte that causes a result pushes an event into the queue as it is accepted; the
// back end moves the head event into the output register when that register is free,
// one result per cycle while the output is not stalled, so a byte that closes both its
// last argument and the command yields two results from one queue entry; the queue
// absorbs these, and the input stalls only when the output side has stalled long
// enough to fill it. After an error the parser drops bytes until the next '*'. The
// argument count limit is the smaller of max_args and 1024. Configuration (index 0
// max_args, index 1 max_bulk_len) is written through cfg_we_i, effective from the next byte.
module resp_command_array_parser_unit import rcap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [29:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [9:0]  arg_index_o,
  output logic [2:0]  err_code_o,
  output logic        last_o
);

  cfg_t         cfg_q;
  logic         accept;
  logic         push, pop;
  event_t       push_event, head_event;
  fifo_status_t fifo_status;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_args     <= MaxArgsRst;
      cfg_q.max_bulk_len <= MaxBulkLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxArgs:    cfg_q.max_args     <= cfg_data_i[10:0];
        CfgMaxBulkLen: cfg_q.max_bulk_len <= cfg_data_i;
        default:       cfg_q              <= cfg_q;
      endcase
    end
  end

  assign in_stall_o = fifo_status.full;
  assign accept     = in_valid_i && !fifo_status.full;

  rcap_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .byte_i   (in_byte_i),
    .push_o   (push),
    .event_o  (push_event)
  );

  rcap_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push && accept),
    .event_i  (push_event),
    .pop_i    (pop),
    .head_o   (head_event),
    .status_o (fifo_status)
  );

  rcap_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_event),
    .status_i    (fifo_status),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .arg_index_o (arg_index_o),
    .err_code_o  (err_code_o),
    .last_o      (last_o)
  );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for resp_command_array_parser_unit: directed byte table, then random
// well-formed and broken RESP requests under several register settings, with random stalls.
// Depends on rcap_pkg and the parser RTL only.
module testbench;
  import rcap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [9:0] arg;
    logic [2:0] err;
    logic       last;
  } event_rec_t;

  // One directed byte; pinned rows carry their single result written out by hand
  typedef struct packed {
    logic [7:0] b;
    logic       pinned;
    event_rec_t res;
  } row_t;

  localparam event_rec_t Unpinned = '0;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_idx_i   = CfgMaxArgs;
  logic [29:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  in_byte_i   = '0;
  logic        out_stall_i = 1'b1;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [9:0]  arg_index_o;
  logic [2:0]  err_code_o;
  logic        last_o;

  resp_command_array_parser_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .arg_index_o (arg_index_o),
    .err_code_o  (err_code_o),
    .last_o      (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Parser mirror state and register copies
  phase_e      parse_ph    = PH_IDLE;
  logic [30:0] num_acc     = '0;
  logic        num_neg     = 1'b0;
  logic        num_digit   = 1'b0;
  logic        num_started = 1'b0;
  logic        num_closed  = 1'b0;
  logic [10:0] args_left   = '0;
  logic [9:0]  arg_ctr     = '0;
  logic [29:0] bytes_left  = '0;
  logic [10:0] lim_args    = MaxArgsRst;
  logic [29:0] lim_bulk    = MaxBulkLenRst;

  event_rec_t  byte_events[$];
  event_rec_t  due_events[$];
  logic [7:0]  cmd_bytes[$];
  row_t        dir_table[29];

  int mismatches = 0;
  int bytes_sent = 0;
  int rx_total   = 0;
  int n_data = 0, n_arg = 0, n_cmd = 0, n_err = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  // ---------------------------------------------------------------- parser mirror

  function automatic int count_limit();
    return (lim_args < MaxArgs) ? int'(lim_args) : int'(MaxArgs);
  endfunction

  function automatic void note(kind_e k, logic [7:0] d, logic [9:0] a, logic [2:0] e);
    event_rec_t r;
    r = '{kind: k, data: d, arg: a, err: e, last: 1'b0};
    byte_events = {byte_events, r};
  endfunction

  function automatic void abort_cmd(logic [2:0] e);
    note(KIND_ERROR, 8'h00, arg_ctr, e);
    parse_ph = PH_SKIP;
  endfunction

  function automatic void num_clear();
    num_acc     = '0;
    num_neg     = 1'b0;
    num_digit   = 1'b0;
    num_started = 1'b0;
    num_closed  = 1'b0;
  endfunction

  // stoi-style digit accumulation with saturation
  function automatic void num_take(logic [7:0] c);
    logic [63:0] wide;
    if (num_closed) return;
    if (c >= Char0 && c <= Char9) begin
      wide = 64'(num_acc) * 64'd10 + 64'(c) - 64'(Char0);
      num_acc = (wide > 64'(AccMax)) ? AccMax : wide[30:0];
      num_digit   = 1'b1;
      num_started = 1'b1;
    end else if (!num_started && (c == CharSpace || (c >= CharTab && c <= CharCr))) begin
      // leading whitespace
    end else if (!num_started && (c == CharPlus || c == CharMinus)) begin
      num_started = 1'b1;
      if (c == CharMinus) num_neg = 1'b1;
    end else begin
      num_closed = 1'b1;
    end
  endfunction

  function automatic void close_arg();
    note(KIND_ARG_END, 8'h00, arg_ctr, 3'd0);
    arg_ctr   = arg_ctr + 10'd1;
    args_left = args_left - 11'd1;
    if (args_left == 0) begin
      note(KIND_CMD_END, 8'h00, 10'd0, 3'd0);
      parse_ph = PH_IDLE;
    end else begin
      parse_ph = PH_MARK;
    end
  endfunction

  function automatic void start_cmd();
    args_left  = '0;
    arg_ctr    = '0;
    bytes_left = '0;
    num_clear();
    parse_ph = PH_CNT;
  endfunction

  function automatic void take_count();
    if (!num_digit || (num_neg && num_acc != 0) || num_acc > 31'(count_limit())) begin
      abort_cmd(ErrCount);
      return;
    end
    args_left = num_acc[10:0];
    arg_ctr   = '0;
    if (args_left == 0) begin
      note(KIND_CMD_END, 8'h00, 10'd0, 3'd0);
      parse_ph = PH_IDLE;
    end else begin
      parse_ph = PH_MARK;
    end
  endfunction

  function automatic void take_length();
    if (!num_digit) begin
      abort_cmd(ErrLength);
      return;
    end
    if (num_neg) begin
      // minus one is a null argument; minus zero falls through as zero
      if (num_acc == 31'd1) begin
        close_arg();
        return;
      end
      if (num_acc != 0) begin
        abort_cmd(ErrLength);
        return;
      end
    end else if (num_acc > 31'(lim_bulk)) begin
      abort_cmd(ErrLength);
      return;
    end
    bytes_left = num_acc[29:0];
    parse_ph = (bytes_left != 0) ? PH_DATA : PH_DATA_CR;
  endfunction

  // Advance the mirror by one byte; results land in byte_events
  function automatic void parse_byte(logic [7:0] c);
    byte_events.delete();
    case (parse_ph)
      PH_IDLE: begin
        if (c == CharStar) start_cmd();
        else abort_cmd(ErrArrayMark);
      end
      PH_CNT, PH_LEN: begin
        if (c == CharCr) parse_ph = (parse_ph == PH_CNT) ? PH_CNT_LF : PH_LEN_LF;
        else num_take(c);
      end
      PH_CNT_LF: begin
        if (c != CharLf) abort_cmd(ErrBareCr);
        else take_count();
      end
      PH_LEN_LF: begin
        if (c != CharLf) abort_cmd(ErrBareCr);
        else take_length();
      end
      PH_MARK: begin
        if (c != CharDollar) abort_cmd(ErrBulkMark);
        else begin
          num_clear();
          parse_ph = PH_LEN;
        end
      end
      PH_DATA: begin
        note(KIND_DATA, c, arg_ctr, 3'd0);
        bytes_left = bytes_left - 30'd1;
        if (bytes_left == 0) parse_ph = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (c != CharCr) abort_cmd(ErrDataCrlf);
        else parse_ph = PH_DATA_LF;
      end
      PH_DATA_LF: begin
        if (c != CharLf) abort_cmd(ErrDataCrlf);
        else close_arg();
      end
      default: begin
        // resync: drop everything up to the next array marker
        if (c == CharStar) start_cmd();
        else parse_ph = PH_SKIP;
      end
    endcase
    if (byte_events.size() != 0) byte_events[byte_events.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- request builders

  function automatic int unsigned pick_wait(inout bit burst);
    if ($urandom_range(0, 49) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [7:0] any_but(logic [7:0] avoid, logic [7:0] alt);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    return (r == avoid) ? alt : r;
  endfunction

  // Append one byte to the request under construction
  function automatic void add_byte(logic [7:0] b);
    cmd_bytes = {cmd_bytes, b};
  endfunction

  // Number line with random leading whitespace, sign, zero padding and trailing text
  function automatic void put_line(string s);
    logic [7:0] j;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 4))
          0: add_byte(CharSpace);
          1: add_byte(CharTab);
          2: add_byte(CharLf);
          3: add_byte(8'h0B);
          default: add_byte(8'h0C);
        endcase
      end
    end
    if (s.len() != 0 && s[0] >= Char0 && s[0] <= Char9) begin
      if ($urandom_range(0, 5) == 0) add_byte(CharPlus);
      if ($urandom_range(0, 5) == 0) add_byte(Char0);
    end
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    if ($urandom_range(0, 5) == 0) begin
      j = any_but(CharCr, "x");
      if (j >= Char0 && j <= Char9) j = CharLf;
      add_byte(j);
      repeat ($urandom_range(0, 2)) add_byte(any_but(CharCr, "y"));
    end
    add_byte(CharCr);
    add_byte(CharLf);
  endfunction

  function automatic void put_arg();
    int unsigned cap, len;
    add_byte(CharDollar);
    case ($urandom_range(0, 7))
      0: put_line("-1");
      1: begin
        put_line("-0");
        add_byte(CharCr);
        add_byte(CharLf);
      end
      default: begin
        cap = (lim_bulk < 30'd8) ? int'(lim_bulk) : 8;
        len = $urandom_range(0, cap);
        put_line($sformatf("%0d", len));
        repeat (len) add_byte(8'($urandom_range(0, 255)));
        add_byte(CharCr);
        add_byte(CharLf);
      end
    endcase
  endfunction

  function automatic void build_good();
    int lim, n;
    lim = count_limit();
    if (lim <= 12 && $urandom_range(0, 7) == 0) n = lim;
    else n = $urandom_range(0, (lim < 4) ? lim : 4);
    add_byte(CharStar);
    put_line($sformatf("%0d", n));
    repeat (n) put_arg();
  endfunction

  // Start of a one-argument request, up to the length line
  function automatic void len_header();
    add_byte(CharStar);
    put_line("1");
    add_byte(CharDollar);
  endfunction

  function automatic void build_broken();
    int unsigned k;
    string s;
    case ($urandom_range(0, 11))
      0: begin
        build_good();
        k = $urandom_range(0, cmd_bytes.size() - 1);
        cmd_bytes[k] = 8'($urandom_range(0, 255));
      end
      1: begin
        build_good();
        repeat ($urandom_range(1, cmd_bytes.size())) cmd_bytes.delete(cmd_bytes.size() - 1);
      end
      2: begin
        add_byte(CharStar);
        put_line($sformatf("%0d", count_limit() + 1));
      end
      3: begin
        add_byte(CharStar);
        put_line($sformatf("-%0d", $urandom_range(1, 9)));
      end
      4: begin
        // long digit strings, mostly well past the accumulator's ceiling
        s = "";
        repeat ($urandom_range(10, 14)) s = {s, $sformatf("%0d", $urandom_range(1, 9))};
        if ($urandom_range(0, 1) == 0) add_byte(CharStar);
        else len_header();
        put_line(s);
      end
      5: begin
        case ($urandom_range(0, 3))
          0: s = "";
          1: s = "+";
          2: s = "-";
          default: s = "x7";
        endcase
        if ($urandom_range(0, 1) == 0) add_byte(CharStar);
        else len_header();
        put_line(s);
      end
      6: begin
        len_header();
        put_line($sformatf("%0d", lim_bulk + 1));
      end
      7: begin
        len_header();
        put_line($sformatf("-%0d", $urandom_range(2, 1000)));
      end
      8: begin
        len_header();
        put_line("1");
        add_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) add_byte(any_but(CharCr, "A"));
        else begin
          add_byte(CharCr);
          add_byte(any_but(CharLf, "B"));
        end
      end
      9: repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      10: begin
        add_byte(CharStar);
        add_byte("3");
        add_byte(CharCr);
        add_byte(any_but(CharLf, "C"));
      end
      default: begin
        add_byte(CharStar);
        put_line("1");
        add_byte(any_but(CharDollar, "D"));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] b, input logic pinned, input event_rec_t pin_res);
    int unsigned gap;
    gap = pick_wait(tx_burst);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    parse_byte(b);
    if (pinned) due_events = {due_events, pin_res};
    else due_events = {due_events, byte_events};
    bytes_sent++;
  endtask

  task automatic send_request();
    foreach (cmd_bytes[i]) send_byte(cmd_bytes[i], 1'b0, Unpinned);
  endtask

  // Hold the input off until every result is out and the pipeline has emptied
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_set(input logic [10:0] args, input logic [29:0] bulk);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgMaxArgs;
    cfg_data_i <= {19'd0, args};
    @(posedge clk_i);
    lim_args    = args;
    cfg_idx_i  <= CfgMaxBulkLen;
    cfg_data_i <= bulk;
    @(posedge clk_i);
    lim_bulk  = bulk;
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : result_checker
    int unsigned wait_left, hold_left;
    event_rec_t exp_ev;
    wait_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (due_events.size() == 0) begin
          $error("unexpected result: kind %0d data %0h arg %0d err %0d",
                 kind_o, data_byte_o, arg_index_o, err_code_o);
          mismatches++;
        end else begin
          exp_ev = due_events.pop_front();
          if (kind_o !== exp_ev.kind) begin
            $error("kind: expected %0d, got %0d", exp_ev.kind, kind_o);
            mismatches++;
          end
          if (data_byte_o !== exp_ev.data) begin
            $error("data_byte: expected %0h, got %0h", exp_ev.data, data_byte_o);
            mismatches++;
          end
          if (arg_index_o !== exp_ev.arg) begin
            $error("arg_index: expected %0d, got %0d", exp_ev.arg, arg_index_o);
            mismatches++;
          end
          if (err_code_o !== exp_ev.err) begin
            $error("err_code: expected %0d, got %0d", exp_ev.err, err_code_o);
            mismatches++;
          end
          if (last_o !== exp_ev.last) begin
            $error("last: expected %0d, got %0d", exp_ev.last, last_o);
            mismatches++;
          end
        end
        rx_total++;
        case (kind_o)
          KIND_DATA:    n_data++;
          KIND_ARG_END: n_arg++;
          KIND_CMD_END: n_cmd++;
          default:      n_err++;
        endcase
        // long hold-offs let the event queue fill and back up the input
        if (rx_total == 100 || rx_total == 300) hold_left = 400;
        wait_left = pick_wait(rx_burst);
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (wait_left != 0) begin
        out_stall_i <= 1'b1;
        wait_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : main_flow
    int unsigned ph_start;
    logic [10:0] args_set;
    logic [29:0] bulk_set;

    dir_table = '{
      '{8'hFF,      1'b1, '{KIND_ERROR,   8'h00, 10'd0, ErrArrayMark, 1'b1}},
      '{CharStar,   1'b0, Unpinned},
      '{CharMinus,  1'b0, Unpinned},
      '{"0",        1'b0, Unpinned},
      '{CharCr,     1'b0, Unpinned},
      '{CharLf,     1'b1, '{KIND_CMD_END, 8'h00, 10'd0, 3'd0,         1'b1}},
      '{CharStar,   1'b0, Unpinned},
      '{CharSpace,  1'b0, Unpinned},
      '{"2",        1'b0, Unpinned},
      '{"z",        1'b0, Unpinned},
      '{CharCr,     1'b0, Unpinned},
      '{CharLf,     1'b0, Unpinned},
      '{CharDollar, 1'b0, Unpinned},
      '{"2",        1'b0, Unpinned},
      '{CharCr,     1'b0, Unpinned},
      '{CharLf,     1'b0, Unpinned},
      '{8'h00,      1'b1, '{KIND_DATA,    8'h00, 10'd0, 3'd0,         1'b1}},
      '{8'hFF,      1'b1, '{KIND_DATA,    8'hFF, 10'd0, 3'd0,         1'b1}},
      '{CharCr,     1'b0, Unpinned},
      '{CharLf,     1'b1, '{KIND_ARG_END, 8'h00, 10'd0, 3'd0,         1'b1}},
      '{CharDollar, 1'b0, Unpinned},
      '{CharMinus,  1'b0, Unpinned},
      '{"1",        1'b0, Unpinned},
      '{CharCr,     1'b0, Unpinned},
      '{CharLf,     1'b0, Unpinned},
      '{CharStar,   1'b0, Unpinned},
      '{CharCr,     1'b0, Unpinned},
      '{"x",        1'b1, '{KIND_ERROR,   8'h00, 10'd0, ErrBareCr,    1'b1}},
      '{"q",        1'b0, Unpinned}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed bytes under reset register values
    foreach (dir_table[i]) send_byte(dir_table[i].b, dir_table[i].pinned, dir_table[i].res);
    settle();

    // register settings: reset values, extremes and a small fixed setting first, then random ones
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin args_set = MaxArgsRst; bulk_set = MaxBulkLenRst; end
        1: begin args_set = 11'd0;      bulk_set = 30'd0;         end
        2: begin args_set = 11'd1024;   bulk_set = 30'd536870912; end
        3: begin args_set = 11'd3;      bulk_set = 30'd5;         end
        4: begin
          args_set = 11'($urandom_range(1, 1024));
          bulk_set = 30'($urandom_range(1, 16));
        end
        default: begin
          args_set = 11'($urandom_range(0, 1024));
          bulk_set = 30'($urandom_range(0, 536870912));
        end
      endcase
      if (ph != 0) cfg_set(args_set, bulk_set);

      // one long request with many short and null arguments
      if (ph == 2) begin
        cmd_bytes.delete();
        add_byte(CharStar);
        put_line("48");
        repeat (48) begin
          add_byte(CharDollar);
          case ($urandom_range(0, 2))
            0: put_line("-1");
            1: begin
              put_line("0");
              add_byte(CharCr);
              add_byte(CharLf);
            end
            default: begin
              put_line("1");
              add_byte(8'($urandom_range(0, 255)));
              add_byte(CharCr);
              add_byte(CharLf);
            end
          endcase
        end
        send_request();
      end

      ph_start = bytes_sent;
      while (bytes_sent - ph_start < 160) begin
        cmd_bytes.delete();
        if ($urandom_range(0, 9) < 7) build_good();
        else build_broken();
        send_request();
        if ($urandom_range(0, 19) == 0) settle();
      end
      settle();
    end

    $display("Covered %0d input bytes over six register settings, %0d results checked:",
             bytes_sent, rx_total);
    $display("  %0d data bytes, %0d argument ends, %0d command ends, %0d errors",
             n_data, n_arg, n_cmd, n_err);
    if (mismatches == 0 && due_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
